### rtl/core/gsa_pkg.sv
// Shared types, register indexes and reset values for the grid scan block.
package gsa_pkg;

    localparam int AXES = 3;
    localparam int AW   = 2;

    localparam logic [2:0] CFG_STEPS = 3'd0;
    localparam logic [2:0] CFG_SCALE = 3'd1;
    localparam logic [2:0] CFG_INIT  = 3'd2;
    localparam logic [2:0] CFG_ROW0  = 3'd3;
    localparam logic [2:0] CFG_ROW1  = 3'd4;
    localparam logic [2:0] CFG_ROW2  = 3'd5;
    localparam logic [2:0] CFG_MAX   = 3'd6;

    localparam logic MODE_START  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    localparam logic [47:0] RST_SCALE = 48'h0100_0100_0100;
    localparam logic [47:0] RST_ROW0  = 48'h0000_0000_4000;
    localparam logic [47:0] RST_ROW1  = 48'h0000_4000_0000;
    localparam logic [47:0] RST_ROW2  = 48'h4000_0000_0000;

    typedef struct packed {
        logic [20:0]      steps;
        logic [47:0]      scale;
        logic [47:0]      init;
        logic [2:0][47:0] geom;
        logic             maximize;
    } t_cfg;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        logic [2:0][15:0] pos;
        logic [31:0]      value;
        logic             done;
    } t_result;

endpackage

### rtl/core/grid_scan_argmin_argmax_top.sv
// Top level of the exhaustive grid search: configuration registers and output register.
//
// Input channel: i_valid, o_stall, i_mode, i_metric_value. A start word (mode 0) carries
// the metric at the initial point; a sample word (mode 1) carries the metric of the point
// last delivered. Every accepted word yields exactly one result word.
// Output channel: o_valid, i_stall, o_pos_x/y/z, o_best_value, o_done_res. The output
// register holds a word while i_stall is high; the back end keeps working until its next result is ready.
// Configuration: i_cfg_valid, o_cfg_ready (always high), i_cfg_index, i_cfg_data; write
// only while no word is in flight.
// Sequencing: a start word, or a sample word that does not finish the grid, passes from
// the queue through S_CALC, S_WAIT, S_GEOM and S_DRAIN to S_OUT and the output register,
// paced by the one shared 17x17 multiplier that forms the scaled offsets and then the nine
// matrix products. A sample word that finishes the grid, or arrives with no walk active,
// goes to S_OUT. Items are processed one at a time; a two-entry queue buffers the input.
// Reset (synchronous, active low) restores the register defaults, clears the extremes,
// points and index to zero and leaves the block idle.
module grid_scan_argmin_argmax_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic signed [31:0] i_metric_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic signed [15:0] o_pos_z,
    output logic signed [31:0] o_best_value,
    output logic               o_done_res,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data
);

    gsa_pkg::t_cfg    r_cfg;
    gsa_pkg::t_item   in_item;
    gsa_pkg::t_item   q_item;
    gsa_pkg::t_result res;
    gsa_pkg::t_result r_out;
    logic             r_ovalid;
    logic             q_valid;
    logic             q_pop;
    logic             res_valid;
    logic             res_ready;

    assign o_cfg_ready   = 1'b1;
    assign in_item.mode  = i_mode;
    assign in_item.value = i_metric_value;
    assign res_ready     = !r_ovalid || !i_stall;

    assign o_valid      = r_ovalid;
    assign o_pos_x      = r_out.pos[0];
    assign o_pos_y      = r_out.pos[1];
    assign o_pos_z      = r_out.pos[2];
    assign o_best_value = r_out.value;
    assign o_done_res   = r_out.done;

    gsa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (in_item),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    gsa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steps    <= '0;
            r_cfg.scale    <= gsa_pkg::RST_SCALE;
            r_cfg.init     <= '0;
            r_cfg.geom[0]  <= gsa_pkg::RST_ROW0;
            r_cfg.geom[1]  <= gsa_pkg::RST_ROW1;
            r_cfg.geom[2]  <= gsa_pkg::RST_ROW2;
            r_cfg.maximize <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gsa_pkg::CFG_STEPS: r_cfg.steps    <= i_cfg_data[20:0];
                gsa_pkg::CFG_SCALE: r_cfg.scale    <= i_cfg_data;
                gsa_pkg::CFG_INIT:  r_cfg.init     <= i_cfg_data;
                gsa_pkg::CFG_ROW0:  r_cfg.geom[0]  <= i_cfg_data;
                gsa_pkg::CFG_ROW1:  r_cfg.geom[1]  <= i_cfg_data;
                gsa_pkg::CFG_ROW2:  r_cfg.geom[2]  <= i_cfg_data;
                gsa_pkg::CFG_MAX:   r_cfg.maximize <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

### rtl/core/gsa_front.sv
// Input stage: accepts words and holds them in a two-entry queue for the back end.
module gsa_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  gsa_pkg::t_item i_item,
    output logic           o_q_valid,
    output gsa_pkg::t_item o_q_item,
    input  logic           i_q_pop
);

    gsa_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;

    assign o_stall   = (r_cnt == 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

### rtl/core/gsa_back.sv
// Back end: tracks the extremes, advances the grid index and computes points on one multiplier.
module gsa_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gsa_pkg::t_cfg    i_cfg,
    input  logic             i_q_valid,
    input  gsa_pkg::t_item   i_q_item,
    output logic             o_q_pop,
    output logic             o_res_valid,
    output gsa_pkg::t_result o_res,
    input  logic             i_res_ready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CALC  = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_GEOM  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam logic [gsa_pkg::AW-1:0] LAST = gsa_pkg::AW'(gsa_pkg::AXES - 1);

    function automatic logic [15:0] sat16(input logic signed [34:0] v);
        if (v > 35'sd32767) begin
            return 16'h7fff;
        end else if (v < -35'sd32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    logic [2:0]                r_state;
    logic                      r_walking;
    logic                      r_done;
    logic [2:0][7:0]           r_idx;
    logic [2:0][15:0]          r_pend;
    logic signed [31:0]        r_hi_val;
    logic signed [31:0]        r_lo_val;
    logic [2:0][15:0]          r_hi_pt;
    logic [2:0][15:0]          r_lo_pt;
    logic [2:0][15:0]          r_c;
    logic signed [34:0]        r_acc;
    logic signed [33:0]        r_prod;
    logic                      r_pv;
    logic                      r_pg;
    logic [gsa_pkg::AW-1:0]    r_pi;
    logic [gsa_pkg::AW-1:0]    r_pj;
    logic [gsa_pkg::AW-1:0]    r_i;
    logic [gsa_pkg::AW-1:0]    r_j;

    logic [2:0][7:0]           adv_idx;
    logic                      adv_wrap;
    logic [8:0]                nx;
    logic signed [8:0]         diff;
    logic signed [16:0]        mul_a;
    logic signed [16:0]        mul_b;
    logic signed [33:0]        mul_p;
    logic signed [34:0]        prod_x;
    logic signed [34:0]        init_x;
    logic signed [34:0]        acc_sum;
    logic signed [34:0]        rnd;
    logic [15:0]               init_lane;
    logic                      issue;

    always_comb begin
        adv_idx  = r_idx;
        adv_wrap = 1'b1;
        nx       = 9'd0;
        for (int i = 0; i < gsa_pkg::AXES; i++) begin
            if (adv_wrap) begin
                nx = {1'b0, r_idx[i]} + 9'd1;
                if (nx > {1'b0, i_cfg.steps[7*i +: 7], 1'b0}) begin
                    adv_idx[i] = 8'd0;
                end else begin
                    adv_idx[i] = nx[7:0];
                    adv_wrap   = 1'b0;
                end
            end
        end
    end

    always_comb begin
        diff = $signed({1'b0, r_idx[r_i]}) - $signed({2'b00, i_cfg.steps[7*r_i +: 7]});
        if (r_state == S_GEOM) begin
            mul_a = {i_cfg.geom[r_i][16*r_j+15], i_cfg.geom[r_i][16*r_j +: 16]};
            mul_b = {r_c[r_j][15], r_c[r_j]};
        end else begin
            mul_a = {{8{diff[8]}}, diff};
            mul_b = {1'b0, i_cfg.scale[16*r_i +: 16]};
        end
    end

    assign mul_p     = mul_a * mul_b;
    assign issue     = (r_state == S_CALC) || (r_state == S_GEOM);
    assign prod_x    = {r_prod[33], r_prod};
    assign init_lane = i_cfg.init[16*r_pi +: 16];
    assign init_x    = {{19{init_lane[15]}}, init_lane};
    assign acc_sum   = ((r_pj == '0) ? 35'sd0 : r_acc) + prod_x;
    assign rnd       = (acc_sum + 35'sd8192) >>> 14;

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_res_valid = (r_state == S_OUT);

    always_comb begin
        o_res.done  = r_done;
        o_res.value = i_cfg.maximize ? r_hi_val : r_lo_val;
        for (int i = 0; i < 3; i++) begin
            if (!r_done) begin
                o_res.pos[i] = r_pend[i];
            end else if (i_cfg.maximize) begin
                o_res.pos[i] = r_hi_pt[i];
            end else begin
                o_res.pos[i] = r_lo_pt[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        r_pg   <= (r_state == S_GEOM);
        r_pi   <= r_i;
        r_pj   <= r_j;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_walking <= 1'b0;
            r_done    <= 1'b0;
            r_idx     <= '0;
            r_pend    <= '0;
            r_hi_val  <= '0;
            r_lo_val  <= '0;
            r_hi_pt   <= '0;
            r_lo_pt   <= '0;
            r_c       <= '0;
            r_acc     <= '0;
            r_pv      <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
        end else begin
            r_pv <= issue;
            if (r_pv) begin
                if (!r_pg) begin
                    r_c[r_pi] <= sat16(init_x + prod_x);
                end else if (r_pj == LAST) begin
                    r_pend[r_pi] <= sat16(rnd);
                end else begin
                    r_acc <= acc_sum;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_i <= '0;
                        r_j <= '0;
                        if (i_q_item.mode == gsa_pkg::MODE_START) begin
                            r_hi_val  <= i_q_item.value;
                            r_lo_val  <= i_q_item.value;
                            r_idx     <= '0;
                            r_walking <= 1'b1;
                            r_done    <= 1'b0;
                            r_state   <= S_CALC;
                            for (int i = 0; i < 3; i++) begin
                                if (i < gsa_pkg::AXES) begin
                                    r_hi_pt[i] <= i_cfg.init[16*i +: 16];
                                    r_lo_pt[i] <= i_cfg.init[16*i +: 16];
                                end else begin
                                    r_hi_pt[i] <= 16'd0;
                                    r_lo_pt[i] <= 16'd0;
                                end
                            end
                        end else if (!r_walking) begin
                            r_done  <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            if (i_q_item.value > r_hi_val) begin
                                r_hi_val <= i_q_item.value;
                                r_hi_pt  <= r_pend;
                            end
                            if (i_q_item.value < r_lo_val) begin
                                r_lo_val <= i_q_item.value;
                                r_lo_pt  <= r_pend;
                            end
                            r_idx <= adv_idx;
                            if (adv_wrap) begin
                                r_walking <= 1'b0;
                                r_done    <= 1'b1;
                                r_state   <= S_OUT;
                            end else begin
                                r_done  <= 1'b0;
                                r_state <= S_CALC;
                            end
                        end
                    end
                end
                S_CALC: begin
                    if (r_i == LAST) begin
                        r_i     <= '0;
                        r_state <= S_WAIT;
                    end else begin
                        r_i <= r_i + gsa_pkg::AW'(1);
                    end
                end
                S_WAIT: begin
                    r_state <= S_GEOM;
                end
                S_GEOM: begin
                    if (r_j == LAST) begin
                        r_j <= '0;
                        if (r_i == LAST) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_i <= r_i + gsa_pkg::AW'(1);
                        end
                    end else begin
                        r_j <= r_j + gsa_pkg::AW'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.done) |-> !r_walking)
        else $error("finished result while the grid walk is still active");

    a_point_walking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.done) |-> r_walking)
        else $error("grid point issued while no walk is active");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo_val <= r_hi_val)
        else $error("lowest value exceeds highest value");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_item.mode == gsa_pkg::MODE_START) |=> (r_walking && r_state == S_CALC))
        else $error("start word did not begin a walk");

endmodule
